### design/dde_pkg.sv
// Shared types and constants for the decimal digit entry controller.
// Holds payload structs, key group struct, codes and widths; no dependencies.
package dde_pkg;

    // field widths
    localparam int VALUE_W  = 27;
    localparam int CNT_W    = 4;
    localparam int POS_W    = 3;
    localparam int CODE_W   = 4;
    localparam int DISP_N   = 8;
    localparam int DISP_W   = DISP_N * CODE_W;
    localparam int CFG_IDX_W = 2;

    // composed value width, enough for nine decimal digits
    localparam int ACC_W = 30;

    // digit codes
    localparam logic [CODE_W-1:0] ZERO_CODE  = 4'd0;
    localparam logic [CODE_W-1:0] ONE_CODE   = 4'd1;
    localparam logic [CODE_W-1:0] NINE_CODE  = 4'd9;
    localparam logic [CODE_W-1:0] BLANK_CODE = 4'd10;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_KEY   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT  = 2'd2;

    // configuration reset values
    localparam logic [CNT_W-1:0]   DIGIT_COUNT_RST = 4'd4;
    localparam logic [VALUE_W-1:0] LOW_LIMIT_RST   = 27'd0;
    localparam logic [VALUE_W-1:0] HIGH_LIMIT_RST  = 27'd9999;

    typedef struct packed {
        logic               cmd;
        logic [VALUE_W-1:0] default_value;
        logic [POS_W-1:0]   start_pos;
        logic               key_cancel;
        logic               key_accept;
        logic               key_left;
        logic               key_right;
        logic               key_down;
        logic               key_up;
    } item_t;

    typedef struct packed {
        logic               done_res;
        logic [VALUE_W-1:0] result_value;
        logic [POS_W-1:0]   cursor_pos;
        logic [DISP_W-1:0]  display_digits;
    } result_t;

    // cursor and digit keys handed to the editor
    typedef struct packed {
        logic left;
        logic right;
        logic down;
        logic up;
    } edit_keys_t;

    // power of ten, evaluated at elaboration only
    function automatic logic [63:0] pow10(input int e);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < e; k++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

### design/dde_digit_split.sv
// Splits a binary default value into decimal digit codes with leading blanks.
// Uses dde_pkg; quotients by powers of ten come from constant reciprocals.
module dde_digit_split #(
    parameter int MAX_DIGITS = 8
) (
    input  logic [dde_pkg::VALUE_W-1:0]                   value,
    input  logic [dde_pkg::CNT_W-1:0]                     used,
    output logic [MAX_DIGITS-1:0][dde_pkg::CODE_W-1:0]    codes
);

    localparam int NQ     = MAX_DIGITS + 1;
    localparam int M_W    = dde_pkg::VALUE_W + 1;
    localparam int PROD_W = dde_pkg::VALUE_W + M_W;

    logic [NQ-1:0][dde_pkg::VALUE_W-1:0] quot;
    logic [NQ-1:0]                       nonzero;
    logic                                too_wide;

    // value / 10^i by multiply with rounded-up reciprocal and shift
    for (genvar i = 0; i < NQ; i++)
    begin : g_quot
        localparam logic [63:0] P      = dde_pkg::pow10(i);
        localparam int          SH     = dde_pkg::VALUE_W + $clog2(P);
        localparam logic [63:0] M_FULL = ((64'd1 << SH) + P - 64'd1) / P;
        localparam logic [M_W-1:0] M   = M_W'(M_FULL);

        logic [PROD_W-1:0] prod;

        assign prod       = PROD_W'(value) * PROD_W'(M);
        assign quot[i]    = dde_pkg::VALUE_W'(prod >> SH);
        assign nonzero[i] = (quot[i] != '0);
    end

    // default needs more digits than in use
    always_comb
    begin
        too_wide = 1'b0;
        for (int k = 1; k < NQ; k++)
        begin
            if (used == dde_pkg::CNT_W'(k))
            begin
                too_wide = nonzero[k];
            end
        end
    end

    // digit i is quot[i] - 10*quot[i+1], only the low nibble matters
    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_code
        logic [dde_pkg::CODE_W-1:0] tens;
        logic [dde_pkg::CODE_W-1:0] digit;

        assign tens  = quot[i+1][dde_pkg::CODE_W-1:0] * 4'd10;
        assign digit = quot[i][dde_pkg::CODE_W-1:0] - tens;

        always_comb
        begin
            if (dde_pkg::CNT_W'(i) >= used)
            begin
                codes[i] = dde_pkg::BLANK_CODE;
            end
            else if (too_wide)
            begin
                codes[i] = dde_pkg::NINE_CODE;
            end
            else if (!nonzero[i])
            begin
                codes[i] = dde_pkg::BLANK_CODE;
            end
            else
            begin
                codes[i] = digit;
            end
        end
    end

endmodule

### design/dde_key_edit.sv
// Cursor movement and digit editing for one key poll.
// Uses dde_pkg for codes and the edit key group.
module dde_key_edit #(
    parameter int MAX_DIGITS = 8,
    parameter int CUR_W      = 3
) (
    input  logic [MAX_DIGITS-1:0][dde_pkg::CODE_W-1:0] store,
    input  logic [CUR_W-1:0]                           cursor,
    input  logic [dde_pkg::CNT_W-1:0]                  used,
    input  dde_pkg::edit_keys_t                        keys,
    output logic [MAX_DIGITS-1:0][dde_pkg::CODE_W-1:0] store_edit,
    output logic [CUR_W-1:0]                           cursor_edit
);

    logic [dde_pkg::CNT_W-1:0]  last;
    logic [dde_pkg::CNT_W-1:0]  cur_ext;
    logic [dde_pkg::CNT_W-1:0]  x_clamp;
    logic [dde_pkg::CNT_W-1:0]  x_inc;
    logic [dde_pkg::CNT_W-1:0]  x_left;
    logic [dde_pkg::CNT_W-1:0]  x_sel;
    logic [dde_pkg::CODE_W-1:0] d_cur;
    logic [dde_pkg::CODE_W-1:0] d_down;
    logic [dde_pkg::CODE_W-1:0] d_up;
    logic [dde_pkg::CODE_W-1:0] d_new;
    logic                       higher;

    // clamp cursor, then left and right with wrap
    always_comb
    begin
        last    = used - 4'd1;
        cur_ext = dde_pkg::CNT_W'(cursor);
        x_clamp = (cur_ext > last) ? last : cur_ext;
        x_inc   = x_clamp + 4'd1;
        if (keys.left)
        begin
            x_left = (x_inc >= used) ? '0 : x_inc;
        end
        else
        begin
            x_left = x_clamp;
        end
        if (keys.right)
        begin
            x_sel = (x_left == '0) ? last : (x_left - 4'd1);
        end
        else
        begin
            x_sel = x_left;
        end
    end

    // selected digit and whether a visible digit sits above it
    always_comb
    begin
        d_cur  = dde_pkg::BLANK_CODE;
        higher = 1'b0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (dde_pkg::CNT_W'(i) == x_sel)
            begin
                d_cur = store[i];
            end
            if ((dde_pkg::CNT_W'(i) > x_sel) && (dde_pkg::CNT_W'(i) < used) &&
                (store[i] != dde_pkg::BLANK_CODE))
            begin
                higher = 1'b1;
            end
        end
    end

    // down, up, then a lone leading zero turns blank
    always_comb
    begin
        if (keys.down)
        begin
            if ((d_cur == dde_pkg::ZERO_CODE) || (d_cur > dde_pkg::BLANK_CODE))
            begin
                d_down = dde_pkg::NINE_CODE;
            end
            else
            begin
                d_down = d_cur - 4'd1;
            end
        end
        else
        begin
            d_down = d_cur;
        end

        if (keys.up)
        begin
            if (d_down == dde_pkg::BLANK_CODE)
            begin
                d_up = dde_pkg::ONE_CODE;
            end
            else if (d_down >= dde_pkg::NINE_CODE)
            begin
                d_up = dde_pkg::ZERO_CODE;
            end
            else
            begin
                d_up = d_down + 4'd1;
            end
        end
        else
        begin
            d_up = d_down;
        end

        d_new = ((d_up == dde_pkg::ZERO_CODE) && !higher) ? dde_pkg::BLANK_CODE : d_up;
    end

    // write back at the selected position
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            store_edit[i] = (dde_pkg::CNT_W'(i) == x_sel) ? d_new : store[i];
        end
    end

    assign cursor_edit = CUR_W'(x_sel);

endmodule

### design/dde_compose_clamp.sv
// Composes stored digits into a value (blanks as zero) or takes the saved
// default, then clamps to the low and high limits. Uses dde_pkg.
module dde_compose_clamp #(
    parameter int MAX_DIGITS = 8
) (
    input  logic [MAX_DIGITS-1:0][dde_pkg::CODE_W-1:0] store,
    input  logic [dde_pkg::CNT_W-1:0]                  used,
    input  logic [dde_pkg::VALUE_W-1:0]                saved_default,
    input  logic                                       take_default,
    input  logic [dde_pkg::VALUE_W-1:0]                low_limit,
    input  logic [dde_pkg::VALUE_W-1:0]                high_limit,
    output logic [dde_pkg::VALUE_W-1:0]                value
);

    logic [MAX_DIGITS-1:0][dde_pkg::ACC_W-1:0] term;
    logic [dde_pkg::ACC_W-1:0]                 sum;
    logic [dde_pkg::ACC_W-1:0]                 pick;
    logic [dde_pkg::ACC_W-1:0]                 low_ext;
    logic [dde_pkg::ACC_W-1:0]                 high_ext;
    logic [dde_pkg::ACC_W-1:0]                 above_low;
    logic [dde_pkg::ACC_W-1:0]                 clamped;

    // each digit times its constant weight
    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_term
        localparam logic [dde_pkg::ACC_W-1:0] WEIGHT = dde_pkg::ACC_W'(dde_pkg::pow10(i));

        always_comb
        begin
            if ((dde_pkg::CNT_W'(i) < used) && (store[i] <= dde_pkg::NINE_CODE))
            begin
                term[i] = dde_pkg::ACC_W'(store[i]) * WEIGHT;
            end
            else
            begin
                term[i] = '0;
            end
        end
    end

    // add up terms
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            sum = sum + term[i];
        end
    end

    // low limit first, high limit wins
    always_comb
    begin
        pick      = take_default ? dde_pkg::ACC_W'(saved_default) : sum;
        low_ext   = dde_pkg::ACC_W'(low_limit);
        high_ext  = dde_pkg::ACC_W'(high_limit);
        above_low = (pick < low_ext) ? low_ext : pick;
        clamped   = (above_low > high_ext) ? high_ext : above_low;
    end

    assign value = clamped[dde_pkg::VALUE_W-1:0];

endmodule

### design/decimal_digit_entry_controller_top.sv
// Top level of the decimal digit entry controller: handshakes, configuration
// registers, entry state and result register. Uses dde_pkg and all dde_ modules.
//
// Usage:
//   item channel (item_valid/item_ready/item_data) carries start and key-poll
//   beats; every item gives exactly one beat on the result channel
//   (result_valid/result_ready/result_data) with done flag, clamped value,
//   cursor and the eight display codes.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes digit count,
//   low limit and high limit; cfg_ready is always high. Write only while idle.
// Pipeline:
//   an accepted item goes from the input register through one pass of logic into
//   the result register, which takes it once the held result beat is taken.
//   One item per cycle sustained while result_ready stays high; the whole
//   pass (digit split by reciprocal multiply, compose and clamp, key edit) sits
//   between these two registers.
// Reset: entry idle, all digits blank, cursor 0, saved default 0, digit count 4,
//   limits 0 and 9999. No clearing pass.
// Stall:
//   a held result blocks the input register only; one more item is still taken
//   into the input register and waits there until the result beat is taken.
module decimal_digit_entry_controller_top #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  dde_pkg::item_t                    item_data,
    output logic                              result_valid,
    input  logic                              result_ready,
    output dde_pkg::result_t                  result_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dde_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dde_pkg::VALUE_W-1:0]       cfg_data
);

    localparam int CUR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // configuration
    logic [dde_pkg::CNT_W-1:0]   digit_count_reg;
    logic [dde_pkg::VALUE_W-1:0] low_limit_reg;
    logic [dde_pkg::VALUE_W-1:0] high_limit_reg;

    // pipeline
    dde_pkg::item_t   item_reg;
    logic             item_valid_reg;
    dde_pkg::result_t result_reg;
    logic             result_valid_reg;
    dde_pkg::result_t result_next;
    logic             advance;

    // entry state
    logic [MAX_DIGITS-1:0][dde_pkg::CODE_W-1:0] store_reg;
    logic [MAX_DIGITS-1:0][dde_pkg::CODE_W-1:0] store_next;
    logic [CUR_W-1:0]                           cursor_reg;
    logic [CUR_W-1:0]                           cursor_next;
    logic [dde_pkg::VALUE_W-1:0]                saved_reg;
    logic [dde_pkg::VALUE_W-1:0]                saved_next;
    logic                                       active_reg;
    logic                                       active_next;

    // datapath
    logic [dde_pkg::CNT_W-1:0]                  used;
    logic [dde_pkg::CNT_W-1:0]                  start_pos_ext;
    logic [MAX_DIGITS-1:0][dde_pkg::CODE_W-1:0] split_codes;
    logic [MAX_DIGITS-1:0][dde_pkg::CODE_W-1:0] store_edit;
    logic [CUR_W-1:0]                           cursor_edit;
    dde_pkg::edit_keys_t                        keys;
    logic [dde_pkg::VALUE_W-1:0]                final_value;
    logic                                       is_start;
    logic                                       finish;
    logic                                       done;

    assign cfg_ready    = 1'b1;
    assign advance      = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // digit count limited to the supported range
    always_comb
    begin
        if (digit_count_reg == '0)
        begin
            used = dde_pkg::CNT_W'(1);
        end
        else if (digit_count_reg > dde_pkg::CNT_W'(MAX_DIGITS))
        begin
            used = dde_pkg::CNT_W'(MAX_DIGITS);
        end
        else
        begin
            used = digit_count_reg;
        end
    end

    // key group for the editor, silenced by cancel or accept
    assign finish     = item_reg.key_cancel || item_reg.key_accept;
    assign keys.left  = item_reg.key_left  && !finish;
    assign keys.right = item_reg.key_right && !finish;
    assign keys.down  = item_reg.key_down  && !finish;
    assign keys.up    = item_reg.key_up    && !finish;
    assign is_start   = (item_reg.cmd == dde_pkg::CMD_START);

    dde_digit_split #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_split (
        .value (item_reg.default_value),
        .used  (used),
        .codes (split_codes)
    );

    dde_key_edit #(
        .MAX_DIGITS (MAX_DIGITS),
        .CUR_W      (CUR_W)
    ) u_edit (
        .store       (store_reg),
        .cursor      (cursor_reg),
        .used        (used),
        .keys        (keys),
        .store_edit  (store_edit),
        .cursor_edit (cursor_edit)
    );

    dde_compose_clamp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_compose (
        .store         (store_reg),
        .used          (used),
        .saved_default (saved_reg),
        .take_default  (item_reg.key_cancel),
        .low_limit     (low_limit_reg),
        .high_limit    (high_limit_reg),
        .value         (final_value)
    );

    // next entry state for the item in the input register
    always_comb
    begin
        store_next    = store_reg;
        cursor_next   = cursor_reg;
        saved_next    = saved_reg;
        active_next   = active_reg;
        done          = 1'b0;
        start_pos_ext = dde_pkg::CNT_W'(item_reg.start_pos);
        if (is_start)
        begin
            saved_next  = item_reg.default_value;
            store_next  = split_codes;
            active_next = 1'b1;
            if (start_pos_ext > (used - 4'd1))
            begin
                cursor_next = CUR_W'(used - 4'd1);
            end
            else
            begin
                cursor_next = CUR_W'(start_pos_ext);
            end
        end
        else if (active_reg)
        begin
            cursor_next = cursor_edit;
            if (finish)
            begin
                done        = 1'b1;
                active_next = 1'b0;
            end
            else
            begin
                store_next = store_edit;
            end
        end
    end

    // result beat contents
    always_comb
    begin
        result_next.done_res     = done;
        result_next.result_value = done ? final_value : '0;
        result_next.cursor_pos   = dde_pkg::POS_W'(cursor_next);
        for (int i = 0; i < dde_pkg::DISP_N; i++)
        begin
            result_next.display_digits[i*dde_pkg::CODE_W +: dde_pkg::CODE_W] =
                dde_pkg::BLANK_CODE;
            if ((i < MAX_DIGITS) && (dde_pkg::CNT_W'(i) < used))
            begin
                result_next.display_digits[i*dde_pkg::CODE_W +: dde_pkg::CODE_W] =
                    store_next[i];
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= dde_pkg::DIGIT_COUNT_RST;
            low_limit_reg   <= dde_pkg::LOW_LIMIT_RST;
            high_limit_reg  <= dde_pkg::HIGH_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dde_pkg::REG_DIGIT_COUNT: digit_count_reg <= cfg_data[dde_pkg::CNT_W-1:0];
                dde_pkg::REG_LOW_LIMIT:   low_limit_reg   <= cfg_data;
                dde_pkg::REG_HIGH_LIMIT:  high_limit_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // handshake valid flags and entry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            store_reg        <= {MAX_DIGITS{dde_pkg::BLANK_CODE}};
            cursor_reg       <= '0;
            saved_reg        <= '0;
            active_reg       <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
                store_reg        <= store_next;
                cursor_reg       <= cursor_next;
                saved_reg        <= saved_next;
                active_reg       <= active_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item_data;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

### bench/testbench.sv
// Self-checking bench for decimal_digit_entry_controller_top: directed and random
// start/key beats, scored against an in-bench predictor of the digit entry logic.
// Depends on dde_pkg and the design sources only.
module testbench;
    import dde_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned VALUE_MAX   = 99999999;

    // key masks, ordered {cancel, accept, left, right, down, up}
    localparam logic [5:0] K_NONE   = 6'b000000;
    localparam logic [5:0] K_CANCEL = 6'b100000;
    localparam logic [5:0] K_ACCEPT = 6'b010000;
    localparam logic [5:0] K_LEFT   = 6'b001000;
    localparam logic [5:0] K_RIGHT  = 6'b000100;
    localparam logic [5:0] K_DOWN   = 6'b000010;
    localparam logic [5:0] K_UP     = 6'b000001;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    item_t                item_data    = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result_data;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [VALUE_W-1:0]   cfg_data     = '0;

    // predictor state: digit store, cursor, saved default, entry flag, registers
    logic [CODE_W-1:0]  digit_shadow [DISP_N];
    int unsigned        cursor_shadow;
    logic [VALUE_W-1:0] default_shadow;
    bit                 entry_open;
    logic [CNT_W-1:0]   count_reg;
    logic [VALUE_W-1:0] low_reg;
    logic [VALUE_W-1:0] high_reg;

    result_t     entry_results_due [$];
    result_t     head_beat;
    int unsigned send_idle_pct  = 10;
    int unsigned recv_idle_pct  = 77;
    int unsigned items_acted    = 0;
    int unsigned beats_checked  = 0;
    int unsigned entries_closed = 0;
    int unsigned cfg_writes     = 0;
    int unsigned failures       = 0;
    int unsigned cycle_count    = 0;

    decimal_digit_entry_controller_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock and cycle count
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic longint unsigned decade(input int unsigned e);
        case (e)
            0: return 64'd1;
            1: return 64'd10;
            2: return 64'd100;
            3: return 64'd1000;
            4: return 64'd10000;
            5: return 64'd100000;
            6: return 64'd1000000;
            7: return 64'd10000000;
            8: return 64'd100000000;
            default: return 64'd1000000000;
        endcase
    endfunction

    // digit count register to positions actually in use
    function automatic int unsigned used_digits(input logic [CNT_W-1:0] cnt);
        if (cnt == 0)
            return 1;
        if (cnt > DISP_N)
            return DISP_N;
        return 32'(cnt);
    endfunction

    function automatic logic [VALUE_W-1:0] clamp_to_limits(input longint unsigned v);
        if (v < low_reg)
            v = 64'(low_reg);
        if (v > high_reg)
            v = 64'(high_reg);
        return v[VALUE_W-1:0];
    endfunction

    // expected result beat for one accepted item, advancing the shadow state
    function automatic result_t step_entry(input item_t it);
        result_t         r;
        int unsigned     n;
        int unsigned     x;
        int unsigned     a;
        int unsigned     d;
        longint unsigned v;
        bit              leading;
        bit              higher;
        n = used_digits(count_reg);
        r = '0;
        if (it.cmd == CMD_START)
        begin
            default_shadow = it.default_value;
            cursor_shadow  = (it.start_pos > n - 1) ? n - 1 : 32'(it.start_pos);
            leading = 1'b1;
            for (a = 0; a < DISP_N; a++)
                digit_shadow[a] = BLANK_CODE;
            // split from the top digit down, leading zeros blank, too wide saturates
            for (a = n; a > 0; a--)
            begin
                if (it.default_value >= decade(n))
                    d = 32'(NINE_CODE);
                else
                    d = 32'((it.default_value / decade(a - 1)) % 10);
                if (d != ZERO_CODE)
                    leading = 1'b0;
                else if (leading)
                    d = 32'(BLANK_CODE);
                digit_shadow[a - 1] = CODE_W'(d);
            end
            entry_open = 1'b1;
        end
        else if (entry_open)
        begin
            x = (cursor_shadow > n - 1) ? n - 1 : cursor_shadow;
            if (it.key_cancel)
            begin
                r.done_res     = 1'b1;
                r.result_value = clamp_to_limits(default_shadow);
            end
            else if (it.key_accept)
            begin
                v = 0;
                for (a = 0; a < n; a++)
                    if (digit_shadow[a] <= NINE_CODE)
                        v += digit_shadow[a] * decade(a);
                r.done_res     = 1'b1;
                r.result_value = clamp_to_limits(v);
            end
            else
            begin
                if (it.key_left)
                    x = (x + 1 >= n) ? 0 : x + 1;
                if (it.key_right)
                    x = (x == 0) ? n - 1 : x - 1;
                if (it.key_down)
                begin
                    d = 32'(digit_shadow[x]);
                    digit_shadow[x] = (d == ZERO_CODE || d > BLANK_CODE) ?
                                      NINE_CODE : CODE_W'(d - 1);
                end
                if (it.key_up)
                begin
                    d = 32'(digit_shadow[x]);
                    if (d == BLANK_CODE)
                        digit_shadow[x] = ONE_CODE;
                    else if (d >= NINE_CODE)
                        digit_shadow[x] = ZERO_CODE;
                    else
                        digit_shadow[x] = CODE_W'(d + 1);
                end
                // a zero with nothing visible above it turns blank
                if (digit_shadow[x] == ZERO_CODE)
                begin
                    higher = 1'b0;
                    for (a = x + 1; a < n; a++)
                        if (digit_shadow[a] != BLANK_CODE)
                            higher = 1'b1;
                    if (!higher)
                        digit_shadow[x] = BLANK_CODE;
                end
            end
            cursor_shadow = x;
            if (r.done_res)
                entry_open = 1'b0;
        end
        r.cursor_pos = cursor_shadow[POS_W-1:0];
        for (a = 0; a < DISP_N; a++)
            r.display_digits[CODE_W*a +: CODE_W] = (a < n) ? digit_shadow[a] : BLANK_CODE;
        return r;
    endfunction

    // beat builders, unused fields filled at random
    function automatic item_t start_beat(input int unsigned value, input int unsigned pos);
        item_t       it;
        logic [63:0] fill;
        fill = {$urandom, $urandom};
        it = fill[$bits(item_t)-1:0];
        it.cmd           = CMD_START;
        it.default_value = value[VALUE_W-1:0];
        it.start_pos     = pos[POS_W-1:0];
        return it;
    endfunction

    function automatic item_t poll_beat(input logic [5:0] keys);
        item_t       it;
        logic [63:0] fill;
        fill = {$urandom, $urandom};
        it = fill[$bits(item_t)-1:0];
        it.cmd = CMD_KEY;
        {it.key_cancel, it.key_accept, it.key_left, it.key_right, it.key_down, it.key_up} = keys;
        return it;
    endfunction

    // result checker
    always @(negedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (entry_results_due.size() == 0)
            begin
                $error("result beat with no expected result pending");
                failures++;
            end
            else
            begin
                head_beat = entry_results_due.pop_front();
                beats_checked++;
                entries_closed += 32'(head_beat.done_res);
                if (result_data.done_res !== head_beat.done_res)
                begin
                    $error("done_res expected %0d got %0d",
                           head_beat.done_res, result_data.done_res);
                    failures++;
                end
                if (result_data.result_value !== head_beat.result_value)
                begin
                    $error("result_value expected %0d got %0d",
                           head_beat.result_value, result_data.result_value);
                    failures++;
                end
                if (result_data.cursor_pos !== head_beat.cursor_pos)
                begin
                    $error("cursor_pos expected %0d got %0d",
                           head_beat.cursor_pos, result_data.cursor_pos);
                    failures++;
                end
                if (result_data.display_digits !== head_beat.display_digits)
                begin
                    $error("display_digits expected %h got %h",
                           head_beat.display_digits, result_data.display_digits);
                    failures++;
                end
            end
        end
    end

    // one item beat, with optional idle cycles in front
    task automatic send_item(input item_t it);
        bit took;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = item_ready;
            if (took)
            begin
                if (it.cmd == CMD_START || entry_open)
                    items_acted++;
                entry_results_due.push_back(step_entry(it));
            end
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (entry_results_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] value);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        case (idx)
            REG_DIGIT_COUNT: count_reg = value[CNT_W-1:0];
            REG_LOW_LIMIT:   low_reg   = value;
            REG_HIGH_LIMIT:  high_reg  = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // all three registers, written once the block has gone quiet
    task automatic reconfigure(input int unsigned cnt, input int unsigned lo,
                               input int unsigned hi);
        drain_results();
        write_reg(REG_DIGIT_COUNT, VALUE_W'(cnt));
        write_reg(REG_LOW_LIMIT, VALUE_W'(lo));
        write_reg(REG_HIGH_LIMIT, VALUE_W'(hi));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // key polls before any start are ignored
    task automatic test_idle_polls();
        send_item(poll_beat(K_UP));
        send_item(poll_beat(K_ACCEPT));
    endtask

    // digit split, blank leading zeros, cursor clamp, restart, saturation, cancel
    task automatic test_start_split();
        send_item(start_beat(0, 0));
        send_item(start_beat(1234, 7));
        send_item(start_beat(10000, 1));
        send_item(poll_beat(K_CANCEL));
    endtask

    // cursor wrap both ways, digit wrap on up, zero to blank, accept
    task automatic test_key_edits();
        send_item(start_beat(105, 0));
        send_item(poll_beat(K_RIGHT));
        send_item(poll_beat(K_LEFT));
        send_item(poll_beat(K_LEFT | K_UP));
        send_item(poll_beat(K_DOWN));
        send_item(poll_beat(K_LEFT | K_DOWN));
        send_item(poll_beat(K_LEFT | K_DOWN));
        send_item(poll_beat(K_UP));
        send_item(poll_beat(K_ACCEPT | K_LEFT | K_UP));
    endtask

    // widest and narrowest counts, an out of range count, crossed limits
    task automatic test_register_extremes();
        reconfigure(8, 500, VALUE_MAX);
        send_item(start_beat(VALUE_MAX, 7));
        send_item(poll_beat(K_ACCEPT));
        send_item(start_beat(3, 0));
        send_item(poll_beat(K_CANCEL | K_ACCEPT));
        reconfigure(1, 0, 5);
        send_item(start_beat(12, 4));
        send_item(poll_beat(K_UP));
        send_item(poll_beat(K_ACCEPT));
        reconfigure(0, 7000, 3);
        send_item(start_beat(4, 5));
        send_item(poll_beat(K_ACCEPT));
    endtask

    // digit count lowered under an open entry pulls the cursor in
    task automatic test_count_lowered();
        reconfigure(15, 0, VALUE_MAX);
        send_item(start_beat(12345678, 6));
        reconfigure(3, VALUE_MAX, VALUE_MAX);
        send_item(poll_beat(K_NONE));
        send_item(poll_beat(K_ACCEPT));
    endtask

    task automatic random_config();
        int unsigned cnt;
        int unsigned lo;
        int unsigned hi;
        int unsigned cap;
        cnt = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
        cap = int'(decade(used_digits(cnt[CNT_W-1:0])) - 1);
        case ($urandom_range(4))
            0:
            begin
                lo = 0;
                hi = VALUE_MAX;
            end
            1:
            begin
                lo = $urandom_range(VALUE_MAX);
                hi = $urandom_range(VALUE_MAX);
            end
            2:
            begin
                lo = $urandom_range(1) ? 0 : $urandom_range(cap);
                hi = lo;
            end
            default:
            begin
                lo = $urandom_range(cap / 4);
                hi = $urandom_range(cap, lo);
            end
        endcase
        reconfigure(cnt, lo, hi);
    endtask

    // mostly a start, a run of edits and a finish; some noise and cut-off entries
    task automatic random_entry();
        int unsigned n;
        int unsigned len;
        int unsigned k;
        int unsigned roll;
        int unsigned value;
        logic [5:0]  keys;
        n = used_digits(count_reg);
        if ($urandom_range(99) < 8)
        begin
            send_item(poll_beat(6'($urandom)));
            return;
        end
        case ($urandom_range(9))
            0, 1:    value = $urandom_range(VALUE_MAX);
            2:       value = $urandom_range(99);
            default: value = $urandom_range(int'(decade(n) - 1));
        endcase
        send_item(start_beat(value, $urandom_range(7)));
        len = $urandom_range(12);
        for (k = 0; k < len; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 2)
                send_item(start_beat($urandom_range(VALUE_MAX), $urandom_range(7)));
            else
            begin
                if (roll < 5)
                    keys = 6'($urandom);
                else if (roll < 35)
                    keys = {2'b00, 4'($urandom)};
                else
                    keys = K_UP << $urandom_range(3);
                send_item(poll_beat(keys));
            end
        end
        roll = $urandom_range(99);
        if (roll >= 10)
        begin
            if (roll < 75)
                keys = K_ACCEPT | 6'(4'($urandom));
            else
                keys = K_CANCEL | 6'(5'($urandom));
            send_item(poll_beat(keys));
        end
    endtask

    task automatic test_random_entries(input int unsigned sender_pct,
                                       input int unsigned receiver_pct,
                                       input int unsigned goal);
        int unsigned goal_end;
        int unsigned next_cfg;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        goal_end = items_acted + goal;
        next_cfg = items_acted + 60;
        while (items_acted < goal_end)
        begin
            if (items_acted >= next_cfg)
            begin
                random_config();
                next_cfg = items_acted + $urandom_range(40, 90);
            end
            random_entry();
        end
    endtask

    // shadow reset, stimulus, final scoring
    initial
    begin
        for (int i = 0; i < DISP_N; i++)
            digit_shadow[i] = BLANK_CODE;
        cursor_shadow  = 0;
        default_shadow = '0;
        entry_open     = 1'b0;
        count_reg      = DIGIT_COUNT_RST;
        low_reg        = LOW_LIMIT_RST;
        high_reg       = HIGH_LIMIT_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_polls();
        test_start_split();
        test_key_edits();
        test_register_extremes();
        test_count_lowered();
        test_random_entries(10, 77, 217);
        test_random_entries(77, 10, 217);
        test_random_entries(0, 0, 216);

        drain_results();
        repeat (8) @(posedge clk);
        if (entry_results_due.size() != 0)
        begin
            $error("%0d expected results never arrived", entry_results_due.size());
            failures++;
        end
        $display("run covered %0d acted-on items and %0d result beats (%0d finished entries)",
                 items_acted, beats_checked, entries_closed);
        $display("%0d register writes across changing digit counts and limits", cfg_writes);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
